// ===== src/sphere_triangle_overlap_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sphere-triangle overlap block
// Shared implication forms with the block clock and reset built in.
// ----------------------------------------------------------------------------
`ifndef SPHERE_TRIANGLE_OVERLAP_DEFINES_SVH
`define SPHERE_TRIANGLE_OVERLAP_DEFINES_SVH

// Same-cycle implication.
`define STO_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sphere_triangle_overlap: assertion failed");

// Next-cycle implication.
`define STO_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sphere_triangle_overlap: assertion failed");

`endif

// ===== src/sto_pkg.sv =====
// ----------------------------------------------------------------------------
// Sphere-triangle overlap package
// Default widths, register indexes and pipeline depth.
// ----------------------------------------------------------------------------
package sto_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int INDEX_WIDTH_DEF = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int PIPE_DEPTH      = 12;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_CENTER_X    = cfg_idx_t'(0);
	localparam cfg_idx_t REG_CENTER_Y    = cfg_idx_t'(1);
	localparam cfg_idx_t REG_CENTER_Z    = cfg_idx_t'(2);
	localparam cfg_idx_t REG_BALL_RADIUS = cfg_idx_t'(3);

endpackage

// ===== src/sto_if.sv =====
// ----------------------------------------------------------------------------
// Sphere-triangle overlap channels
// Triangle request, verdict and configuration write channels.
// ----------------------------------------------------------------------------
interface sto_tri_if #(
	parameter int COORD_WIDTH = sto_pkg::COORD_WIDTH_DEF,
	parameter int INDEX_WIDTH = sto_pkg::INDEX_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] vertex_a_x;
	logic signed [COORD_WIDTH-1:0] vertex_a_y;
	logic signed [COORD_WIDTH-1:0] vertex_a_z;
	logic signed [COORD_WIDTH-1:0] vertex_b_x;
	logic signed [COORD_WIDTH-1:0] vertex_b_y;
	logic signed [COORD_WIDTH-1:0] vertex_b_z;
	logic signed [COORD_WIDTH-1:0] vertex_c_x;
	logic signed [COORD_WIDTH-1:0] vertex_c_y;
	logic signed [COORD_WIDTH-1:0] vertex_c_z;
	logic [INDEX_WIDTH-1:0]        triangle_index;

	modport source (
		output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
			vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, triangle_index,
		input  ready
	);
	modport sink (
		input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
			vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, triangle_index,
		output ready
	);
endinterface

interface sto_res_if #(
	parameter int INDEX_WIDTH = sto_pkg::INDEX_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   hit;
	logic [INDEX_WIDTH-1:0] hit_index;

	modport source (output valid, hit, hit_index, input ready);
	modport sink (input valid, hit, hit_index, output ready);
endinterface

interface sto_cfg_if #(
	parameter int COORD_WIDTH = sto_pkg::COORD_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	sto_pkg::cfg_idx_t      index;
	logic [COORD_WIDTH-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/sphere_triangle_overlap.sv =====
// ----------------------------------------------------------------------------
// Sphere-triangle overlap
// Separating-axis test of one triangle per request against a configured ball.
// ----------------------------------------------------------------------------
// The block accepts one triangle request every clock cycle unless stalled, and
// returns verdicts in order. It holds three rounds of exact multiplies (dot
// and cross products, then the region vectors, then the squared terms), the
// first registered in a single stage and the other two each in a two-stage
// split multiplier, plus the add and compare stages between them. The whole
// pipeline advances together: when a verdict is held because the sink is not
// ready, request ready drops in the same cycle and nothing in flight is lost.
// The user must write centre and radius through the configuration channel only
// while no request is in flight; the block itself does not enforce this.
`include "sphere_triangle_overlap_defines.svh"

module sphere_triangle_overlap #(
	parameter int COORD_WIDTH = sto_pkg::COORD_WIDTH_DEF,
	parameter int INDEX_WIDTH = sto_pkg::INDEX_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	sto_cfg_if.sink   cfg,
	sto_tri_if.sink   triangle,
	sto_res_if.source verdict
);

	localparam int W    = COORD_WIDTH;
	localparam int CW   = W + 1;
	localparam int EW   = W + 2;
	localparam int P1W  = 2 * W + 4;
	localparam int S1W  = 2 * W + 7;
	localparam int RRW  = 2 * W;
	localparam int RW   = 2 * W + 1;
	localparam int M2W  = EW + S1W;
	localparam int Q2W  = M2W + 2;
	localparam int NNW  = 2 * S1W + 2;
	localparam int REW  = RW + S1W;
	localparam int L3W  = 2 * Q2W + 2;
	localparam int LAT  = sto_pkg::PIPE_DEPTH;
	localparam int E_DLY    = 3;
	localparam int VSEP_DLY = 6;
	localparam int DOT_A [6] = '{0, 0, 0, 1, 1, 2};
	localparam int DOT_B [6] = '{0, 1, 2, 1, 2, 2};

	logic                   adv;
	logic signed [W-1:0]    center_q [3];
	logic [W-1:0]           radius_q;
	logic [RRW-1:0]         rr_q;
	logic signed [RW-1:0]   rr_sgn;
	logic [LAT-1:0]         vld_q;
	logic signed [W-1:0]    vin [3][3];

	logic signed [CW-1:0]   rel_s1 [3][3];
	logic signed [CW-1:0]   rel_s2 [3][3];
	logic signed [EW-1:0]   edg_s2 [4][3];
	logic signed [CW-1:0]   rel_s3 [3][3];
	logic signed [EW-1:0]   edg_s3 [3][3];
	logic signed [P1W-1:0]  ncp_s3 [6];
	logic signed [P1W-1:0]  dp_s3 [6][3];
	logic signed [P1W-1:0]  ep_s3 [3][3];
	logic signed [CW-1:0]   rel_s4 [3][3];
	logic signed [EW-1:0]   edg_s4 [3][3];
	logic signed [S1W-1:0]  n_s4 [3];
	logic signed [S1W-1:0]  dot_s4 [6];
	logic signed [S1W-1:0]  e_s4 [3];
	logic signed [CW-1:0]   rel_s5 [3][3];
	logic signed [EW-1:0]   edg_s5 [3][3];
	logic signed [S1W-1:0]  n_s5 [3];
	logic signed [S1W-1:0]  e_s5 [3];
	logic signed [S1W-1:0]  d_s5 [3];
	logic                   vsep_s5;

	logic signed [EW-1:0]      l2_vec [10][3];
	logic signed [S1W-1:0]     l2_scl [10][3];
	logic signed [M2W-1:0]     m2_p [10][3];
	logic signed [2*S1W-1:0]   nn_p [3];
	logic signed [REW-1:0]     rre_p [3];
	logic [S1W-1:0]            e_d8_raw [3];
	logic signed [S1W-1:0]     e_d8 [3];

	logic signed [Q2W-1:0]     dn_s8;
	logic signed [NNW-1:0]     nn_s8;
	logic signed [Q2W-1:0]     q_s8 [6][3];
	logic signed [REW-1:0]     rre_s8 [3];

	logic signed [2*Q2W-1:0]   dd_p;
	logic signed [RW+NNW-1:0]  rn_p;
	logic signed [2*Q2W-1:0]   qq_p [3][3];
	logic signed [2*Q2W-1:0]   qo_p [3][3];
	logic signed [REW+S1W-1:0] ree_p [3];

	logic                      plane_s11;
	logic signed [L3W-1:0]     qq_s11 [3];
	logic signed [L3W-1:0]     qo_s11 [3];
	logic signed [L3W-1:0]     ree_s11 [3];
	logic                      vsep_s11;
	logic [2:0]                edge_sep;
	logic                      hit_s12;
	logic [INDEX_WIDTH-1:0]    index_d;

	assign adv            = !vld_q[LAT-1] || verdict.ready;
	assign triangle.ready = adv;
	assign cfg.ready      = 1'b1;
	assign rr_sgn         = {1'b0, rr_q};

	assign vin[0][0] = triangle.vertex_a_x;
	assign vin[0][1] = triangle.vertex_a_y;
	assign vin[0][2] = triangle.vertex_a_z;
	assign vin[1][0] = triangle.vertex_b_x;
	assign vin[1][1] = triangle.vertex_b_y;
	assign vin[1][2] = triangle.vertex_b_z;
	assign vin[2][0] = triangle.vertex_c_x;
	assign vin[2][1] = triangle.vertex_c_y;
	assign vin[2][2] = triangle.vertex_c_z;

	// Configuration, radius square and the valid bits that travel with requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			radius_q    <= '0;
			rr_q        <= '0;
			vld_q       <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					sto_pkg::REG_CENTER_X:    center_q[0] <= cfg.data;
					sto_pkg::REG_CENTER_Y:    center_q[1] <= cfg.data;
					sto_pkg::REG_CENTER_Z:    center_q[2] <= cfg.data;
					sto_pkg::REG_BALL_RADIUS: radius_q    <= cfg.data;
					default: ;
				endcase
			end
			rr_q <= RRW'(radius_q) * RRW'(radius_q);
			if (adv) begin
				vld_q <= {vld_q[LAT-2:0], triangle.valid};
			end
		end
	end

	// Stages 1 to 5: relative vertices, edges, first products and their sums.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					rel_s1[k][i] <= CW'(vin[k][i]) - CW'(center_q[i]);
				end
			end

			rel_s2 <= rel_s1;
			for (int i = 0; i < 3; i++) begin
				edg_s2[0][i] <= EW'(rel_s1[1][i]) - EW'(rel_s1[0][i]);
				edg_s2[1][i] <= EW'(rel_s1[2][i]) - EW'(rel_s1[1][i]);
				edg_s2[2][i] <= EW'(rel_s1[0][i]) - EW'(rel_s1[2][i]);
				edg_s2[3][i] <= EW'(rel_s1[2][i]) - EW'(rel_s1[0][i]);
			end

			rel_s3 <= rel_s2;
			for (int k = 0; k < 3; k++) begin
				edg_s3[k] <= edg_s2[k];
			end
			ncp_s3[0] <= P1W'(edg_s2[0][1]) * P1W'(edg_s2[3][2]);
			ncp_s3[1] <= P1W'(edg_s2[0][2]) * P1W'(edg_s2[3][1]);
			ncp_s3[2] <= P1W'(edg_s2[0][2]) * P1W'(edg_s2[3][0]);
			ncp_s3[3] <= P1W'(edg_s2[0][0]) * P1W'(edg_s2[3][2]);
			ncp_s3[4] <= P1W'(edg_s2[0][0]) * P1W'(edg_s2[3][1]);
			ncp_s3[5] <= P1W'(edg_s2[0][1]) * P1W'(edg_s2[3][0]);
			for (int j = 0; j < 6; j++) begin
				for (int i = 0; i < 3; i++) begin
					dp_s3[j][i] <= P1W'(rel_s2[DOT_A[j]][i]) * P1W'(rel_s2[DOT_B[j]][i]);
				end
			end
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					ep_s3[k][i] <= P1W'(edg_s2[k][i]) * P1W'(edg_s2[k][i]);
				end
			end

			rel_s4 <= rel_s3;
			edg_s4 <= edg_s3;
			n_s4[0] <= S1W'(ncp_s3[0]) - S1W'(ncp_s3[1]);
			n_s4[1] <= S1W'(ncp_s3[2]) - S1W'(ncp_s3[3]);
			n_s4[2] <= S1W'(ncp_s3[4]) - S1W'(ncp_s3[5]);
			for (int j = 0; j < 6; j++) begin
				dot_s4[j] <= S1W'(dp_s3[j][0]) + S1W'(dp_s3[j][1]) + S1W'(dp_s3[j][2]);
			end
			for (int k = 0; k < 3; k++) begin
				e_s4[k] <= S1W'(ep_s3[k][0]) + S1W'(ep_s3[k][1]) + S1W'(ep_s3[k][2]);
			end

			rel_s5 <= rel_s4;
			edg_s5 <= edg_s4;
			n_s5   <= n_s4;
			e_s5   <= e_s4;
			d_s5[0] <= dot_s4[1] - dot_s4[0];
			d_s5[1] <= dot_s4[4] - dot_s4[3];
			d_s5[2] <= dot_s4[2] - dot_s4[5];
			// A vertex region separates when the ball lies beyond that vertex
			// and behind both of its edges.
			vsep_s5 <= (dot_s4[0] > S1W'(rr_sgn) && dot_s4[1] > dot_s4[0] &&
					dot_s4[2] > dot_s4[0]) ||
				(dot_s4[3] > S1W'(rr_sgn) && dot_s4[1] > dot_s4[3] &&
					dot_s4[4] > dot_s4[3]) ||
				(dot_s4[5] > S1W'(rr_sgn) && dot_s4[2] > dot_s4[5] &&
					dot_s4[4] > dot_s4[5]);
		end
	end

	// Second round of products: plane distance, normal length, region vectors.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			l2_vec[0][i] = EW'(rel_s5[0][i]); l2_scl[0][i] = e_s5[0];
			l2_vec[1][i] = edg_s5[0][i];      l2_scl[1][i] = d_s5[0];
			l2_vec[2][i] = EW'(rel_s5[1][i]); l2_scl[2][i] = e_s5[1];
			l2_vec[3][i] = edg_s5[1][i];      l2_scl[3][i] = d_s5[1];
			l2_vec[4][i] = EW'(rel_s5[2][i]); l2_scl[4][i] = e_s5[2];
			l2_vec[5][i] = edg_s5[2][i];      l2_scl[5][i] = d_s5[2];
			l2_vec[6][i] = EW'(rel_s5[2][i]); l2_scl[6][i] = e_s5[0];
			l2_vec[7][i] = EW'(rel_s5[0][i]); l2_scl[7][i] = e_s5[1];
			l2_vec[8][i] = EW'(rel_s5[1][i]); l2_scl[8][i] = e_s5[2];
			l2_vec[9][i] = EW'(rel_s5[0][i]); l2_scl[9][i] = n_s5[i];
		end
	end

	for (genvar j = 0; j < 10; j++) begin : g_l2_row
		for (genvar i = 0; i < 3; i++) begin : g_l2_col
			sto_mul #(.AW(EW), .BW(S1W)) u_mul (
				.clk (clk),
				.en  (adv),
				.a   (l2_vec[j][i]),
				.b   (l2_scl[j][i]),
				.p   (m2_p[j][i])
			);
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_l2_aux
		sto_mul #(.AW(S1W), .BW(S1W)) u_nn (
			.clk (clk),
			.en  (adv),
			.a   (n_s5[k]),
			.b   (n_s5[k]),
			.p   (nn_p[k])
		);
		sto_mul #(.AW(RW), .BW(S1W)) u_rre (
			.clk (clk),
			.en  (adv),
			.a   (rr_sgn),
			.b   (e_s5[k]),
			.p   (rre_p[k])
		);
		sto_dly #(.WIDTH(S1W), .DEPTH(E_DLY)) u_e_dly (
			.clk (clk),
			.en  (adv),
			.d   (e_s5[k]),
			.q   (e_d8_raw[k])
		);
		assign e_d8[k] = e_d8_raw[k];
	end

	// Stage 8: sums of the second round. The far-edge vectors fold q0..q2 in.
	always_ff @(posedge clk) begin
		if (adv) begin
			dn_s8 <= Q2W'(m2_p[9][0]) + Q2W'(m2_p[9][1]) + Q2W'(m2_p[9][2]);
			nn_s8 <= NNW'(nn_p[0]) + NNW'(nn_p[1]) + NNW'(nn_p[2]);
			rre_s8 <= rre_p;
			for (int i = 0; i < 3; i++) begin
				q_s8[0][i] <= Q2W'(m2_p[0][i]) - Q2W'(m2_p[1][i]);
				q_s8[1][i] <= Q2W'(m2_p[2][i]) - Q2W'(m2_p[3][i]);
				q_s8[2][i] <= Q2W'(m2_p[4][i]) - Q2W'(m2_p[5][i]);
				q_s8[3][i] <= Q2W'(m2_p[6][i]) - Q2W'(m2_p[0][i]) + Q2W'(m2_p[1][i]);
				q_s8[4][i] <= Q2W'(m2_p[7][i]) - Q2W'(m2_p[2][i]) + Q2W'(m2_p[3][i]);
				q_s8[5][i] <= Q2W'(m2_p[8][i]) - Q2W'(m2_p[4][i]) + Q2W'(m2_p[5][i]);
			end
		end
	end

	// Third round of products: all squared terms for the final compares.
	sto_mul #(.AW(Q2W), .BW(Q2W)) u_dd (
		.clk (clk),
		.en  (adv),
		.a   (dn_s8),
		.b   (dn_s8),
		.p   (dd_p)
	);

	sto_mul #(.AW(RW), .BW(NNW)) u_rn (
		.clk (clk),
		.en  (adv),
		.a   (rr_sgn),
		.b   (nn_s8),
		.p   (rn_p)
	);

	for (genvar k = 0; k < 3; k++) begin : g_l3_edge
		for (genvar i = 0; i < 3; i++) begin : g_l3_comp
			sto_mul #(.AW(Q2W), .BW(Q2W)) u_qq (
				.clk (clk),
				.en  (adv),
				.a   (q_s8[k][i]),
				.b   (q_s8[k][i]),
				.p   (qq_p[k][i])
			);
			sto_mul #(.AW(Q2W), .BW(Q2W)) u_qo (
				.clk (clk),
				.en  (adv),
				.a   (q_s8[k][i]),
				.b   (q_s8[k+3][i]),
				.p   (qo_p[k][i])
			);
		end
		sto_mul #(.AW(REW), .BW(S1W)) u_ree (
			.clk (clk),
			.en  (adv),
			.a   (rre_s8[k]),
			.b   (e_d8[k]),
			.p   (ree_p[k])
		);
	end

	sto_dly #(.WIDTH(1), .DEPTH(VSEP_DLY)) u_vsep_dly (
		.clk (clk),
		.en  (adv),
		.d   (vsep_s5),
		.q   (vsep_s11)
	);

	sto_dly #(.WIDTH(INDEX_WIDTH), .DEPTH(LAT)) u_index_dly (
		.clk (clk),
		.en  (adv),
		.d   (triangle.triangle_index),
		.q   (index_d)
	);

	// Stages 11 and 12: plane compare, edge sums, then the verdict.
	always_ff @(posedge clk) begin
		if (adv) begin
			plane_s11 <= L3W'(dd_p) > L3W'(rn_p);
			for (int k = 0; k < 3; k++) begin
				qq_s11[k]  <= L3W'(qq_p[k][0]) + L3W'(qq_p[k][1]) + L3W'(qq_p[k][2]);
				qo_s11[k]  <= L3W'(qo_p[k][0]) + L3W'(qo_p[k][1]) + L3W'(qo_p[k][2]);
				ree_s11[k] <= L3W'(ree_p[k]);
			end
			hit_s12 <= !(plane_s11 || vsep_s11 || (|edge_sep));
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			edge_sep[k] = (qq_s11[k] > ree_s11[k]) && !qo_s11[k][L3W-1] &&
				(qo_s11[k] != '0);
		end
	end

	assign verdict.valid     = vld_q[LAT-1];
	assign verdict.hit       = hit_s12;
	assign verdict.hit_index = index_d;

	`STO_ASSERT_NXT(a_stall_holds, !adv, vld_q == $past(vld_q))
	`STO_ASSERT_NXT(a_request_enters, triangle.valid && triangle.ready, vld_q[0])
	`STO_ASSERT_NXT(a_radius_square, 1'b1, rr_q == RRW'($past(radius_q)) * RRW'($past(radius_q)))
	`STO_ASSERT_IMP(a_held_blocks_input, verdict.valid && !verdict.ready, !triangle.ready)

endmodule

// ===== src/sto_mul.sv =====
// ----------------------------------------------------------------------------
// Two-stage signed multiplier
// Splits both operands into halves, registers four partial products, then
// sums them in the second stage.
// ----------------------------------------------------------------------------
module sto_mul #(
	parameter int AW = 18,
	parameter int BW = 39
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);

	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic signed [AH-1:0]    ah;
	logic [AL-1:0]           al;
	logic signed [BH-1:0]    bh;
	logic [BL-1:0]           bl;
	logic signed [AL:0]      al_x;
	logic signed [BL:0]      bl_x;
	logic signed [AH+BH-1:0] hh_s1;
	logic signed [AH+BL:0]   hl_s1;
	logic signed [AL+BH:0]   lh_s1;
	logic [AL+BL-1:0]        ll_s1;
	logic signed [PW-1:0]    t_hh;
	logic signed [PW-1:0]    t_hl;
	logic signed [PW-1:0]    t_lh;
	logic signed [PW-1:0]    t_ll;

	assign ah   = a[AW-1:AL];
	assign al   = a[AL-1:0];
	assign bh   = b[BW-1:BL];
	assign bl   = b[BL-1:0];
	assign al_x = {1'b0, al};
	assign bl_x = {1'b0, bl};

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= ah * bh;
			hl_s1 <= ah * bl_x;
			lh_s1 <= al_x * bh;
			ll_s1 <= al * bl;
		end
	end

	assign t_hh = hh_s1;
	assign t_hl = hl_s1;
	assign t_lh = lh_s1;
	assign t_ll = PW'(ll_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			p <= (t_hh <<< (AL + BL)) + (t_hl <<< AL) + (t_lh <<< BL) + t_ll;
		end
	end

endmodule

// ===== src/sto_dly.sv =====
// ----------------------------------------------------------------------------
// Pipeline delay line
// Carries a value alongside the pipeline for a fixed number of stages.
// ----------------------------------------------------------------------------
module sto_dly #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] taps_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			taps_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end
	end

	assign q = taps_q[DEPTH-1];

endmodule
